/* rtl/u16u8_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// u16u8_pkg
// Types and constants shared by the UTF-16 (with BOM) to UTF-8 encoder.
// ----------------------------------------------------------------------------
package u16u8_pkg;

    localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [15:0] BOM_LE       = 16'hFEFF;
    localparam logic [15:0] BOM_BE       = 16'hFFFE;
    localparam logic [15:0] LIMIT_1B     = 16'h007F;
    localparam logic [15:0] LIMIT_2B     = 16'h07FF;
    localparam logic [15:0] SWAP_HI_MASK = 16'hFF00;
    localparam logic [7:0]  LEAD_2B      = 8'hC0;
    localparam logic [7:0]  LEAD_3B      = 8'hE0;
    localparam logic [7:0]  CONT_MARK    = 8'h80;
    localparam logic [7:0]  CONT_MASK    = 8'h3F;
    localparam logic [7:0]  TERM_BYTE    = 8'h00;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        last_unit;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
        logic       status;
    } out_item_t;

    // One unit's worth of output bytes, as queued between front and back.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;  // index of final byte in this word
        logic            term;      // final byte ends the string
        logic            status;    // missing byte-order mark
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage : u16u8_pkg
`default_nettype wire

/* rtl/u16u8_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// u16u8_front
// Tracks byte order per string and turns each code unit into a byte job.
// ----------------------------------------------------------------------------
module u16u8_front
    import u16u8_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_data,
    input  wire q_status_t q_stat,
    output logic           q_push,
    output job_t           q_job
);

    typedef enum logic [1:0] {
        MODE_WAIT,
        MODE_LE,
        MODE_BE,
        MODE_DROP
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic        accept;
    logic        emit;
    logic [15:0] u;
    job_t        job;

    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        u         = s_data.code_unit;
        mode_next = mode_reg;
        emit      = 1'b0;
        job       = '0;
        case (mode_reg)
            MODE_WAIT: begin
                if (u == BOM_LE || u == BOM_BE) begin
                    mode_next = (u == BOM_LE) ? MODE_LE : MODE_BE;
                    if (s_data.last_unit) begin
                        emit          = 1'b1;
                        job.bytes[0]  = TERM_BYTE;
                        job.term      = 1'b1;
                        mode_next     = MODE_WAIT;
                    end
                end else begin
                    emit         = 1'b1;
                    job.bytes[0] = TERM_BYTE;
                    job.term     = 1'b1;
                    job.status   = 1'b1;
                    mode_next    = s_data.last_unit ? MODE_WAIT : MODE_DROP;
                end
            end
            MODE_LE, MODE_BE: begin
                emit = 1'b1;
                if (mode_reg == MODE_BE) begin
                    u = ((s_data.code_unit << 8) & SWAP_HI_MASK) | (s_data.code_unit >> 8);
                end
                if (u <= LIMIT_1B) begin
                    job.bytes[0] = u[7:0];
                    job.last_idx = 2'd0;
                end else if (u <= LIMIT_2B) begin
                    job.bytes[0] = LEAD_2B | {3'b000, u[10:6]};
                    job.bytes[1] = CONT_MARK | ({2'b00, u[5:0]} & CONT_MASK);
                    job.last_idx = 2'd1;
                end else begin
                    job.bytes[0] = LEAD_3B | {4'b0000, u[15:12]};
                    job.bytes[1] = CONT_MARK | ({2'b00, u[11:6]} & CONT_MASK);
                    job.bytes[2] = CONT_MARK | ({2'b00, u[5:0]} & CONT_MASK);
                    job.last_idx = 2'd2;
                end
                if (s_data.last_unit) begin
                    // terminator goes right after the unit's bytes
                    job.bytes[job.last_idx + 2'd1] = TERM_BYTE;
                    job.last_idx                   = job.last_idx + 2'd1;
                    job.term                       = 1'b1;
                    mode_next                      = MODE_WAIT;
                end
            end
            MODE_DROP: begin
                if (s_data.last_unit) begin
                    mode_next = MODE_WAIT;
                end
            end
            default: begin
                mode_next = MODE_WAIT;
            end
        endcase
    end

    assign q_push = accept && emit;
    assign q_job  = job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_WAIT;
        end else if (accept) begin
            mode_reg <= mode_next;
        end
    end

endmodule : u16u8_front
`default_nettype wire

/* rtl/u16u8_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// u16u8_queue
// Small FIFO of byte jobs between the classifier and the byte serializer.
// ----------------------------------------------------------------------------
module u16u8_queue
    import u16u8_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire job_t push_job,
    input  wire logic pop,
    output job_t      head_job,
    output q_status_t stat
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign head_job   = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule : u16u8_queue
`default_nettype wire

/* rtl/u16u8_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// u16u8_back
// Serializes the head job one byte per cycle into output reg unless stalled.
// ----------------------------------------------------------------------------
module u16u8_back
    import u16u8_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire job_t      head_job,
    input  wire q_status_t q_stat,
    output logic           q_pop,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data
);

    logic       m_valid_reg;
    out_item_t  m_data_reg, m_data_next;
    logic [1:0] idx_reg;
    logic       load;
    logic       at_end;

    // output slot frees when empty or when its word is taken this cycle
    assign load   = !q_stat.empty && (!m_valid_reg || m_ready);
    assign at_end = (idx_reg == head_job.last_idx);
    assign q_pop  = load && at_end;

    always_comb begin
        m_data_next.out_byte  = head_job.bytes[idx_reg];
        m_data_next.last_byte = head_job.term && at_end;
        m_data_next.status    = head_job.status;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
        end else begin
            if (load) begin
                m_valid_reg <= 1'b1;
                idx_reg     <= at_end ? 2'd0 : idx_reg + 2'd1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule : u16u8_back
`default_nettype wire

/* rtl/bom_utf16_to_utf8_encoder_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bom_utf16_to_utf8_encoder_unit
// UTF-16 string with leading byte-order mark in, UTF-8 bytes plus terminator out.
// ----------------------------------------------------------------------------
//  channel | dir | word        | fields
//  s_      | in  | in_item_t   | code_unit[15:0], last_unit
//  m_      | out | out_item_t  | out_byte[7:0], last_byte, status
//
//  A unit is taken whenever the job queue has room; it leaves as 0 to 4
//  bytes (its UTF-8 form, plus one for a terminator), one per cycle while
//  the output is not stalled, from the byte serializer. Each byte is
//  held in the job queue, then in the output register. Reset clears byte order,
//  queue and output valid. Either side may stall; the queue absorbs the rest.
// ----------------------------------------------------------------------------
module bom_utf16_to_utf8_encoder_unit
    import u16u8_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output out_item_t     m_data
);

    q_status_t q_stat;
    logic      q_push, q_pop;
    job_t      q_job, head_job;

    u16u8_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_stat  (q_stat),
        .q_push  (q_push),
        .q_job   (q_job)
    );

    u16u8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (q_job),
        .pop      (q_pop),
        .head_job (head_job),
        .stat     (q_stat)
    );

    u16u8_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_job (head_job),
        .q_stat   (q_stat),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_push && q_stat.full))
        else $error("job pushed into full queue");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_stat.empty)
        else $error("job popped from empty queue");

    a_error_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status) |-> (m_data.last_byte && m_data.out_byte == TERM_BYTE))
        else $error("error word not a final zero byte");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");

endmodule : bom_utf16_to_utf8_encoder_unit
`default_nettype wire
